FILE: sv/lidar_sample_stream_parser_macros.svh
// ----------------------------------------------------------------------------
// Lidar sample stream parser - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef LIDAR_SAMPLE_STREAM_PARSER_MACROS_SVH
`define LIDAR_SAMPLE_STREAM_PARSER_MACROS_SVH

// checked only while out of reset
`define LSSP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("lssp assertion failed");

// checked on every edge, reset included
`define LSSP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("lssp assertion failed");

`endif

FILE: sv/lssp_pkg.sv
// ----------------------------------------------------------------------------
// Lidar sample stream parser - package
// Constants, register indexes and the sample type shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lssp_pkg;

    localparam int SAMPLE_BYTES    = 5;
    localparam int WIN_DEPTH       = SAMPLE_BYTES - 1;
    localparam int WIN_IDX_W       = $clog2(WIN_DEPTH);
    localparam int SCNT_W          = $clog2(SAMPLE_BYTES);

    localparam int DEF_HEADER_BYTES = 7;
    localparam int DEF_QUEUE_DEPTH  = 2;

    localparam int ANGLE_W   = 15;
    localparam int DIST_W    = 16;
    localparam int QUAL_W    = 6;
    localparam int BYTE_W    = 8;

    localparam int OUT_FIELDS_W = ANGLE_W + DIST_W + QUAL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DIST   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DIST   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_STEP = 2'd2;

    localparam logic [DIST_W-1:0]  RST_MIN_DIST   = 16'h0000;
    localparam logic [DIST_W-1:0]  RST_MAX_DIST   = 16'hFFFF;
    localparam logic [ANGLE_W-1:0] RST_ANGLE_STEP = 15'd64;

    localparam logic [BYTE_W-1:0] HDR_SYNC0 = 8'hA5;
    localparam logic [BYTE_W-1:0] HDR_SYNC1 = 8'h5A;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic [QUAL_W-1:0]  quality;
        logic [DIST_W-1:0]  range_qmm;
        logic [ANGLE_W-1:0] azimuth;
    } t_sample;

endpackage

`default_nettype wire

FILE: sv/lssp_front.sv
// ----------------------------------------------------------------------------
// Lidar sample stream parser - front end
// Start response hunt, sample window, packet checks and config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lssp_front
    import lssp_pkg::*;
#(
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  i_op,
    input  wire logic [BYTE_W-1:0]     i_byte,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                       o_push,
    output t_sample                    o_sample
);

    localparam int HCNT_W = $clog2(HEADER_BYTES);

    logic [DIST_W-1:0]  r_min_dist;
    logic [DIST_W-1:0]  r_max_dist;
    logic [ANGLE_W-1:0] r_angle_step;

    logic               r_sample_mode, n_sample_mode;
    logic [HCNT_W-1:0]  r_hcnt, n_hcnt;
    logic [SCNT_W-1:0]  r_scnt, n_scnt;
    logic [ANGLE_W-1:0] r_last_angle, n_last_angle;
    logic [BYTE_W-1:0]  r_win [WIN_DEPTH];
    logic [BYTE_W-1:0]  n_win [WIN_DEPTH];

    logic [ANGLE_W-1:0] ang;
    logic [DIST_W-1:0]  dist_word;
    logic [QUAL_W-1:0]  qual;
    logic [ANGLE_W-1:0] ang_diff;
    logic               pkt_ok;
    logic               win_full;
    logic               emit;

    assign qual      = r_win[0][7:2];
    assign ang       = {r_win[2], r_win[1][7:1]};
    assign dist_word = {i_byte, r_win[3]};
    assign ang_diff  = ang - r_last_angle;
    assign win_full  = (r_scnt == SCNT_W'(SAMPLE_BYTES - 1));

    assign pkt_ok = (r_win[0][0] ^ r_win[0][1])
                  && (qual != '0)
                  && (dist_word >= r_min_dist) && (dist_word <= r_max_dist)
                  && !((ang >= r_last_angle) && (ang_diff < r_angle_step));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist   <= RST_MIN_DIST;
            r_max_dist   <= RST_MAX_DIST;
            r_angle_step <= RST_ANGLE_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MIN_DIST:   r_min_dist   <= i_cfg_wdata;
                CFG_MAX_DIST:   r_max_dist   <= i_cfg_wdata;
                CFG_ANGLE_STEP: r_angle_step <= i_cfg_wdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_sample_mode = r_sample_mode;
        n_hcnt        = r_hcnt;
        n_scnt        = r_scnt;
        n_last_angle  = r_last_angle;
        n_win         = r_win;
        emit          = 1'b0;
        if (i_valid) begin
            if (i_op == OP_RESTART) begin
                n_sample_mode = 1'b0;
                n_hcnt        = '0;
            end else if (!r_sample_mode) begin
                if (r_hcnt == '0) begin
                    if (i_byte == HDR_SYNC0) begin
                        n_hcnt = HCNT_W'(1);
                    end
                end else if (r_hcnt == HCNT_W'(1)) begin
                    n_hcnt = (i_byte == HDR_SYNC1) ? HCNT_W'(2) : '0;
                end else if (r_hcnt == HCNT_W'(HEADER_BYTES - 1)) begin
                    n_sample_mode = 1'b1;
                    n_hcnt        = '0;
                end else begin
                    n_hcnt = r_hcnt + HCNT_W'(1);
                end
            end else if (!win_full) begin
                n_win[r_scnt[WIN_IDX_W-1:0]] = i_byte;
                n_scnt = r_scnt + SCNT_W'(1);
            end else if (pkt_ok) begin
                emit         = 1'b1;
                n_scnt       = '0;
                n_last_angle = ang;
            end else begin
                // drop oldest byte, keep four
                for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                    n_win[k] = r_win[k+1];
                end
                n_win[WIN_DEPTH-1] = i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_mode <= 1'b0;
            r_hcnt        <= '0;
            r_scnt        <= '0;
            r_last_angle  <= '0;
        end else begin
            r_sample_mode <= n_sample_mode;
            r_hcnt        <= n_hcnt;
            r_scnt        <= n_scnt;
            r_last_angle  <= n_last_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign o_push             = emit;
    assign o_sample.azimuth   = ang;
    assign o_sample.range_qmm = dist_word;
    assign o_sample.quality   = qual;

endmodule

`default_nettype wire

FILE: sv/lssp_queue.sv
// ----------------------------------------------------------------------------
// Lidar sample stream parser - sample queue
// Small register FIFO between the front end and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lssp_queue
    import lssp_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_sample i_sample,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_pop,
    output t_sample      o_sample
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_sample            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_pop;

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign do_pop   = i_pop && o_valid;
    assign o_sample = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/lidar_sample_stream_parser.sv
// Latency: a sample is offered on the master side the cycle after its last byte is taken.
// Throughput: one word per cycle; the front end checks a full packet in the cycle of its
// last byte, and s_axis_tready falls only while the QUEUE_DEPTH sample queue is full.
// Reset: synchronous, active low; registers return to defaults, the parser hunts for the
// start response, the queue empties; the sample window bytes are not cleared.
// ----------------------------------------------------------------------------
// Lidar sample stream parser - top level
// Byte stream in, checked lidar samples out.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_sample_stream_parser
    import lssp_pkg::*;
#(
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
    input  wire logic                   s_axis_tuser,   // [0] op
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [14:0] azimuth, [30:15] range,
                                                        // [36:31] quality, rest zero
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic    full;
    logic    accept;
    logic    push;
    t_sample front_sample;
    t_sample out_sample;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    lssp_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_op        (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push),
        .o_sample    (front_sample)
    );

    lssp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sample (front_sample),
        .o_full   (full),
        .o_valid  (m_axis_tvalid),
        .i_pop    (m_axis_tready),
        .o_sample (out_sample)
    );

    assign m_axis_tdata = OUT_TDATA_W'(out_sample);

endmodule

`default_nettype wire

FILE: sv/lssp_checker.sv
// ----------------------------------------------------------------------------
// Lidar sample stream parser - port checker
// Concurrent assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lidar_sample_stream_parser_macros.svh"

module lssp_checker
    import lssp_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [BYTE_W-1:0]      s_axis_tdata,
    input wire logic                   s_axis_tuser,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   i_cfg_we,
    input wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic restart_in;
    logic [QUAL_W-1:0] out_qual;

    assign restart_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_RESTART)
                      && (s_axis_tdata == s_axis_tdata) && !i_cfg_we
                      && (i_cfg_addr == i_cfg_addr) && (i_cfg_wdata == i_cfg_wdata);
    assign out_qual   = m_axis_tdata[ANGLE_W+DIST_W +: QUAL_W];

    `LSSP_ASSERT_ALWAYS(a_idle_after_reset, i_clk, $past(!i_rst_n) |-> !m_axis_tvalid)

    `LSSP_ASSERT(a_out_held, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

    `LSSP_ASSERT(a_quality_nonzero, i_clk, i_rst_n, m_axis_tvalid |-> out_qual != '0)

    `LSSP_ASSERT(a_pad_zero, i_clk, i_rst_n,
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0)

    `LSSP_ASSERT(a_restart_quiet, i_clk, i_rst_n,
        restart_in && !m_axis_tvalid |=> !m_axis_tvalid)

endmodule

bind lidar_sample_stream_parser lssp_checker u_lssp_checker (.*);

`default_nettype wire

FILE: bench/lidar_sample_stream_parser_tb.sv
// ----------------------------------------------------------------------------
// Lidar sample stream parser - testbench
// Drives received bytes and restarts into the parser and checks each emitted
// sample against a predictor held in the bench. It covers the start-response
// hunt, the packet checks, resuming after a restart, and register settings
// including their extremes. The sender works in bursts and the receiver
// stalls on its own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_sample_stream_parser_tb;
    import lssp_pkg::*;

    localparam int HDR_LEN     = DEF_HEADER_BYTES;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_BYTE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = CFG_MIN_DIST;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    lidar_sample_stream_parser #(
        .HEADER_BYTES(HDR_LEN)
    ) dut (.*);

    // parser state as the bench sees it
    logic               synced     = 1'b0;
    int unsigned        sync_count = 0;
    logic [BYTE_W-1:0]  pkt_win [SAMPLE_BYTES];
    int unsigned        pkt_fill   = 0;
    logic [ANGLE_W-1:0] prev_angle = '0;
    logic [DIST_W-1:0]  min_dist   = RST_MIN_DIST;
    logic [DIST_W-1:0]  max_dist   = RST_MAX_DIST;
    logic [ANGLE_W-1:0] angle_step = RST_ANGLE_STEP;

    t_sample     expected_samples [$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned words_sent  = 0;
    int          burst_left  = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall pattern
    int rx_mode = 0;
    int rx_left = 0;
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    task automatic flag_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : check_samples
        t_sample want;
        t_sample seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = m_axis_tdata[OUT_FIELDS_W-1:0];
            if (expected_samples.size() == 0) begin
                flag_mismatch("unexpected sample", '0, 64'(m_axis_tdata));
            end else begin
                want = expected_samples.pop_front();
                if (seen.azimuth !== want.azimuth)
                    flag_mismatch("azimuth", 64'(want.azimuth), 64'(seen.azimuth));
                if (seen.range_qmm !== want.range_qmm)
                    flag_mismatch("range", 64'(want.range_qmm), 64'(seen.range_qmm));
                if (seen.quality !== want.quality)
                    flag_mismatch("quality", 64'(want.quality), 64'(seen.quality));
                if (m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0)
                    flag_mismatch("tdata padding", '0,
                                  64'(m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]));
            end
        end
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        rand_byte = BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic parse_word(input logic op, input logic [BYTE_W-1:0] b);
        logic [QUAL_W-1:0]  q;
        logic [ANGLE_W-1:0] ang;
        logic [DIST_W-1:0]  dist_word;
        t_sample            smp;
        int                 k;
        if (op == OP_RESTART) begin
            synced     = 1'b0;
            sync_count = 0;
        end else if (!synced) begin
            if (sync_count == 0) begin
                if (b == HDR_SYNC0) sync_count = 1;
            end else if (sync_count == 1) begin
                sync_count = (b == HDR_SYNC1) ? 2 : 0;
            end else begin
                sync_count++;
                if (sync_count >= HDR_LEN) begin
                    synced     = 1'b1;
                    sync_count = 0;
                end
            end
        end else begin
            if (pkt_fill >= SAMPLE_BYTES) pkt_fill = SAMPLE_BYTES - 1;
            pkt_win[pkt_fill] = b;
            pkt_fill++;
            if (pkt_fill == SAMPLE_BYTES) begin
                q         = pkt_win[0][7:2];
                ang       = {pkt_win[2], pkt_win[1][7:1]};
                dist_word = {pkt_win[4], pkt_win[3]};
                if ((pkt_win[0][0] ^ pkt_win[0][1]) && q != '0
                        && dist_word >= min_dist && dist_word <= max_dist
                        && !(ang >= prev_angle && (ang - prev_angle) < angle_step)) begin
                    smp.azimuth   = ang;
                    smp.range_qmm = dist_word;
                    smp.quality   = q;
                    expected_samples.push_back(smp);
                    prev_angle = ang;
                    pkt_fill   = 0;
                end else begin
                    for (k = 0; k < SAMPLE_BYTES - 1; k++) pkt_win[k] = pkt_win[k + 1];
                    pkt_fill = SAMPLE_BYTES - 1;
                end
            end
        end
    endtask

    task automatic send_word(input logic op, input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left <= 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk) s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        if (!(op == OP_BYTE && !synced && sync_count == 0 && b != HDR_SYNC0)) words_sent++;
        parse_word(op, b);
    endtask

    task automatic idle_until_drained;
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        case (idx)
            CFG_MIN_DIST:   min_dist = val;
            CFG_MAX_DIST:   max_dist = val;
            CFG_ANGLE_STEP: angle_step = val[ANGLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] hi,
                              input logic [ANGLE_W-1:0] step);
        logic spare;
        spare = 1'($urandom_range(0, 1));
        idle_until_drained();
        write_reg(CFG_MIN_DIST, lo);
        write_reg(CFG_MAX_DIST, hi);
        write_reg(CFG_ANGLE_STEP, {spare, step});
    endtask

    task automatic send_header(input bit good);
        int k;
        if (good) begin
            send_word(OP_BYTE, HDR_SYNC0);
            send_word(OP_BYTE, HDR_SYNC1);
            for (k = 2; k < HDR_LEN; k++) send_word(OP_BYTE, rand_byte());
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    send_word(OP_BYTE, HDR_SYNC0);
                    send_word(OP_BYTE, rand_byte());
                end
                1: send_word(OP_BYTE, rand_byte());
                default: begin
                    send_word(OP_BYTE, HDR_SYNC0);
                    send_word(OP_BYTE, HDR_SYNC1);
                    send_word(OP_RESTART, rand_byte());
                end
            endcase
        end
    endtask

    function automatic logic [ANGLE_W-1:0] pick_angle();
        int unsigned span;
        span = angle_step + 2;
        case ($urandom_range(0, 3))
            0: pick_angle = ANGLE_W'($urandom_range(0, 32767));
            1: pick_angle = prev_angle + ANGLE_W'($urandom_range(0, span + span / 2));
            2: pick_angle = prev_angle - ANGLE_W'($urandom_range(1, span));
            default: pick_angle = prev_angle + angle_step - ANGLE_W'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance();
        if (min_dist > max_dist) begin
            pick_distance = DIST_W'($urandom_range(0, 65535));
        end else begin
            case ($urandom_range(0, 7))
                0: pick_distance = min_dist;
                1: pick_distance = max_dist;
                default: pick_distance = DIST_W'($urandom_range(max_dist, min_dist));
            endcase
        end
    endfunction

    // well-formed packet with random content, now and then with one or more flaws
    task automatic send_sample_packet;
        logic [QUAL_W-1:0]  q;
        logic               s;
        logic               chk;
        logic [ANGLE_W-1:0] ang;
        logic [DIST_W-1:0]  dist_word;
        logic [BYTE_W-1:0]  b0;
        q         = QUAL_W'($urandom_range(1, 63));
        s         = 1'($urandom_range(0, 1));
        chk       = 1'($urandom_range(0, 1));
        ang       = pick_angle();
        dist_word = pick_distance();
        b0        = {q, ~s, s};
        case ($urandom_range(0, 11))
            0: b0[7:2] = '0;
            1: b0[1] = s;
            2: begin
                if (min_dist > 0) begin
                    dist_word = DIST_W'($urandom_range(0, min_dist - 1));
                end else if (max_dist < 16'hFFFF) begin
                    dist_word = DIST_W'($urandom_range(max_dist + 1, 16'hFFFF));
                end
            end
            default: ;
        endcase
        send_word(OP_BYTE, b0);
        send_word(OP_BYTE, {ang[6:0], chk});
        send_word(OP_BYTE, ang[14:7]);
        send_word(OP_BYTE, dist_word[7:0]);
        send_word(OP_BYTE, dist_word[15:8]);
    endtask

    task automatic run_random_words(input int n);
        int unsigned start;
        start = words_sent;
        while (words_sent - start < n) begin
            if (!synced) begin
                send_header($urandom_range(0, 9) != 0);
            end else begin
                case ($urandom_range(0, 19))
                    0: send_word(OP_RESTART, rand_byte());
                    1, 2: repeat ($urandom_range(1, 3)) send_word(OP_BYTE, rand_byte());
                    3: begin
                        repeat ($urandom_range(1, 4)) send_word(OP_BYTE, rand_byte());
                        send_word(OP_RESTART, rand_byte());
                    end
                    default: send_sample_packet();
                endcase
            end
        end
    endtask

    // stray byte ignored, A5 A5 drops the hunt, then a full start response
    task automatic test_header_hunt;
        send_word(OP_BYTE, 8'h3C);
        send_word(OP_BYTE, HDR_SYNC0);
        send_word(OP_BYTE, HDR_SYNC0);
        send_word(OP_BYTE, HDR_SYNC0);
        send_word(OP_BYTE, HDR_SYNC1);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h00);
    endtask

    // largest angle and distance, then a sample that steps back to a small angle
    task automatic test_sample_checks;
        send_word(OP_BYTE, 8'hFD);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h05);
        send_word(OP_BYTE, 8'h7E);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'h10);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'h00);
    endtask

    // partial packet survives a restart and completes after the next header
    task automatic test_restart_resume;
        send_word(OP_BYTE, 8'h06);
        send_word(OP_BYTE, 8'h01);
        send_word(OP_RESTART, 8'hA5);
        send_header(1'b1);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'h00);
    endtask

    task automatic test_register_sweep;
        logic [DIST_W-1:0] lo;
        logic [DIST_W-1:0] hi;
        set_limits(16'h0000, 16'hFFFF, 15'd64);
        run_random_words(300);
        set_limits(16'h0000, 16'h0000, 15'd0);
        run_random_words(250);
        set_limits(16'hFFFF, 16'hFFFF, 15'h7FFF);
        run_random_words(200);
        set_limits(16'h8000, 16'h7FFF, 15'd100);
        run_random_words(150);
        lo = DIST_W'($urandom_range(0, 32767));
        hi = DIST_W'($urandom_range(lo, 65535));
        set_limits(lo, hi, ANGLE_W'($urandom_range(0, 512)));
        run_random_words(400);
        set_limits(DIST_W'($urandom_range(0, 65535)), DIST_W'($urandom_range(0, 65535)),
                   ANGLE_W'($urandom_range(0, 32767)));
        run_random_words(350);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        test_header_hunt();
        test_sample_checks();
        test_restart_resume();
        test_register_sweep();
        idle_until_drained();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
